// ===== src/v210_group_to_rgb_defines.svh =====
// Assertion macros for the v210 converter checker.
`ifndef V210_GROUP_TO_RGB_DEFINES_SVH
`define V210_GROUP_TO_RGB_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define V2G_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define V2G_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/v2g_pkg.sv =====
// Shared types, constants and arithmetic helpers for the v210 to BGR converter.
package v2g_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int SAMPLE_W   = 10;
    localparam int PIXEL_W    = 24;
    localparam int NUM_PIXELS = 6;
    localparam int NUM_LANES  = 3;
    localparam int COUNT_W    = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 152;
    localparam int COUNT_LSB  = NUM_PIXELS * PIXEL_W;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_VAL_W  = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_WIDTH   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 4'd1;

    localparam logic [CFG_VAL_W-1:0] RST_LINE_WIDTH   = 13'd1920;
    localparam logic [CFG_VAL_W-1:0] RST_FRAME_HEIGHT = 13'd1080;

    // n/6 == (n * DIV6_MUL) >> DIV6_SHIFT for every n below 2^17
    localparam logic [31:0] DIV6_MUL   = 32'd43691;
    localparam int          DIV6_SHIFT = 18;

    localparam int ACC_W  = 29;
    localparam int FRAC_W = 17;

    localparam logic signed [16:0] KY2 = 17'sd38030;
    localparam logic signed [16:0] KRV = 17'sd29290;
    localparam logic signed [16:0] KGV = 17'sd8723;
    localparam logic signed [16:0] KGU = 17'sd3480;
    localparam logic signed [16:0] KBU = 17'sd34551;
    localparam logic signed [ACC_W-1:0] YOFF = 29'sd2441085;

    typedef struct packed {
        logic               produce;
        logic [COUNT_W-1:0] pix_count;
        logic               line_end;
        logic               frame_end;
    } ctrl_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // Truncate to integer, clamp to 0..255.
    function automatic logic [7:0] chan(input logic signed [ACC_W-1:0] acc);
        logic [7:0] v;
        if (acc[ACC_W-1]) begin
            v = 8'd0;
        end else if (|acc[ACC_W-2:FRAC_W+8]) begin
            v = 8'd255;
        end else begin
            v = acc[FRAC_W+7:FRAC_W];
        end
        return v;
    endfunction

    function automatic pixel_t to_bgr(input logic signed [ACC_W-1:0] base,
                                      input logic signed [ACC_W-1:0] rv,
                                      input logic signed [ACC_W-1:0] gv,
                                      input logic signed [ACC_W-1:0] gu,
                                      input logic signed [ACC_W-1:0] bu);
        logic signed [ACC_W-1:0] b0;
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] g;
        logic signed [ACC_W-1:0] b;
        b0 = base - YOFF;
        r  = b0 + rv;
        g  = b0 - gv - gu;
        b  = b0 + bu;
        return {chan(r), chan(g), chan(b)};
    endfunction

endpackage

// ===== src/v2g_lane.sv =====
// One conversion lane: a pixel pair sharing one chroma pair, two register stages.
module v2g_lane (
    input  logic                          aclk,
    input  logic                          en_b,
    input  logic                          en_c,
    input  logic [v2g_pkg::SAMPLE_W-1:0]  y0,
    input  logic [v2g_pkg::SAMPLE_W-1:0]  y1,
    input  logic [v2g_pkg::SAMPLE_W-1:0]  cb,
    input  logic [v2g_pkg::SAMPLE_W-1:0]  cr,
    output v2g_pkg::pixel_t [1:0]         pix
);
    import v2g_pkg::*;

    logic signed [11:0] du;
    logic signed [11:0] dv;

    logic signed [ACC_W-1:0] base0_reg;
    logic signed [ACC_W-1:0] base1_reg;
    logic signed [ACC_W-1:0] rv_reg;
    logic signed [ACC_W-1:0] gv_reg;
    logic signed [ACC_W-1:0] gu_reg;
    logic signed [ACC_W-1:0] bu_reg;
    pixel_t [1:0]            pix_reg;

    // Center chroma: 2*C - 1023
    assign du = $signed({1'b0, cb, 1'b0}) - 12'sd1023;
    assign dv = $signed({1'b0, cr, 1'b0}) - 12'sd1023;

    always_ff @(posedge aclk) begin
        if (en_b) begin
            base0_reg <= KY2 * $signed({1'b0, y0});
            base1_reg <= KY2 * $signed({1'b0, y1});
            rv_reg    <= KRV * dv;
            gv_reg    <= KGV * dv;
            gu_reg    <= KGU * du;
            bu_reg    <= KBU * du;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_c) begin
            pix_reg[0] <= to_bgr(base0_reg, rv_reg, gv_reg, gu_reg, bu_reg);
            pix_reg[1] <= to_bgr(base1_reg, rv_reg, gv_reg, gu_reg, bu_reg);
        end
    end

    assign pix = pix_reg;

endmodule

// ===== src/v2g_pos.sv =====
// Geometry registers and the group/line position counter.
module v2g_pos #(
    parameter int MAX_WIDTH  = v2g_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = v2g_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [v2g_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [v2g_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           advance,
    output v2g_pkg::ctrl_t                 ctrl
);
    import v2g_pkg::*;

    localparam int MAX_GROUPS = (MAX_WIDTH + 5) / 6;
    localparam int MAX_TOTAL  = (MAX_GROUPS + 7) / 8 * 8;
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int GRP_W      = $clog2(MAX_TOTAL + 1);
    localparam int PIX_W      = $clog2(6 * MAX_TOTAL + 1);
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic                 wr_w;
    logic                 wr_h;
    logic [CFG_VAL_W-1:0] raw_w;
    logic [CFG_VAL_W-1:0] raw_h;
    logic [31:0]          w32;
    logic [31:0]          h32;
    logic [31:0]          hl32;
    logic [31:0]          prod32;
    logic [31:0]          grps32;
    logic [31:0]          total32;

    logic [WID_W-1:0] width_reg;
    logic [GRP_W-1:0] grps_reg;
    logic [GRP_W-1:0] total_reg;
    logic [ROW_W-1:0] hlast_reg;

    logic [GRP_W-1:0] gi_reg, gi_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [GRP_W:0]   gi_inc;
    logic [PIX_W-1:0] rem;
    logic             wrap;
    logic             last_row;
    logic             line_end;

    always_comb begin
        wr_w = 1'b0;
        wr_h = 1'b0;
        if (cfg_valid) begin
            case (cfg_addr)
                CFG_LINE_WIDTH:   wr_w = 1'b1;
                CFG_FRAME_HEIGHT: wr_h = 1'b1;
                default: ;
            endcase
        end
    end

    // Reset loads the geometry through the same path as a write
    always_comb begin
        raw_w = aresetn ? cfg_data[CFG_VAL_W-1:0] : RST_LINE_WIDTH;
        raw_h = aresetn ? cfg_data[CFG_VAL_W-1:0] : RST_FRAME_HEIGHT;

        w32 = 32'(raw_w);
        if (w32 == 32'd0) begin
            w32 = 32'd1;
        end else if (w32 > 32'(MAX_WIDTH)) begin
            w32 = 32'(MAX_WIDTH);
        end
        prod32  = (w32 + 32'd5) * DIV6_MUL;
        grps32  = prod32 >> DIV6_SHIFT;
        total32 = (grps32 + 32'd7) & ~32'd7;

        h32 = 32'(raw_h);
        if (h32 == 32'd0) begin
            h32 = 32'd1;
        end else if (h32 > 32'(MAX_HEIGHT)) begin
            h32 = 32'(MAX_HEIGHT);
        end
        hl32 = h32 - 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || wr_w) begin
            width_reg <= w32[WID_W-1:0];
            grps_reg  <= grps32[GRP_W-1:0];
            total_reg <= total32[GRP_W-1:0];
        end
        if (!aresetn || wr_h) begin
            hlast_reg <= hl32[ROW_W-1:0];
        end
    end

    always_comb begin
        gi_inc   = (GRP_W+1)'(gi_reg) + 1'b1;
        wrap     = gi_inc >= {1'b0, total_reg};
        line_end = gi_inc == {1'b0, grps_reg};
        last_row = row_reg >= hlast_reg;
        rem      = PIX_W'(width_reg) - pix_reg;

        ctrl.produce   = gi_reg < grps_reg;
        ctrl.pix_count = (rem > PIX_W'(6)) ? COUNT_W'(6) : rem[COUNT_W-1:0];
        ctrl.line_end  = line_end;
        ctrl.frame_end = line_end & last_row;

        gi_next  = gi_reg;
        pix_next = pix_reg;
        row_next = row_reg;
        if (advance) begin
            if (wrap) begin
                gi_next  = '0;
                pix_next = '0;
                row_next = last_row ? '0 : ROW_W'(row_reg + 1'b1);
            end else begin
                gi_next  = gi_inc[GRP_W-1:0];
                pix_next = PIX_W'(pix_reg + PIX_W'(6));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gi_reg  <= '0;
            pix_reg <= '0;
            row_reg <= '0;
        end else begin
            gi_reg  <= gi_next;
            pix_reg <= pix_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== src/v2g_out.sv =====
// Merge stage: gathers the lane pixels, blanks unused slots, holds the result.
module v2g_out (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    input  v2g_pkg::pixel_t [v2g_pkg::NUM_PIXELS-1:0] in_pix,
    input  v2g_pkg::ctrl_t                          in_ctrl,
    output logic                                    in_ready,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output v2g_pkg::pixel_t [v2g_pkg::NUM_PIXELS-1:0] out_pix,
    output v2g_pkg::ctrl_t                          out_ctrl
);
    import v2g_pkg::*;

    logic                        valid_reg;
    pixel_t [NUM_PIXELS-1:0]     pix_reg, pix_next;
    ctrl_t                       ctrl_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int i = 0; i < NUM_PIXELS; i++) begin
            pix_next[i] = (COUNT_W'(i) < in_ctrl.pix_count) ? in_pix[i] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pix_reg  <= pix_next;
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

// ===== src/v210_group_to_rgb.sv =====
// Top level of the v210 group to BGR888 converter.
// Takes one 128-bit v210 group (six pixels) per clock, sustained while m_tready is high,
// and returns up to six 8-bit BGR pixels with a valid count, end-of-line (m_tlast) and
// end-of-frame (m_tuser) flags. An accepted group passes the unpack register, the
// multiplier stage, the sum/clamp stage and the output register; the multiplier and
// sum/clamp stages sit in the three pixel-pair lanes. Padding groups that fill a line up
// to a multiple of eight groups are taken without a result. The user must write
// line_width and frame_height through the cfg port only while the stream is idle; the
// block does not enforce this. Values out of range are clamped.
module v210_group_to_rgb #(
    parameter int MAX_WIDTH  = v2g_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = v2g_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // word0 31:0, word1 63:32, word2 95:64, word3 127:96
    input  logic [v2g_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pixel0 23:0 .. pixel5 143:120, pixel_count 146:144, zero pad 151:147
    output logic [v2g_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // frame_end 0
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [v2g_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [v2g_pkg::CFG_DATA_W-1:0] cfg_data
);
    import v2g_pkg::*;

    logic  accept;
    logic  ready_a, ready_b, ready_c, ready_o;
    logic  va_reg, vb_reg, vc_reg;
    ctrl_t ctrl_cur;
    ctrl_t ctrl_a_reg, ctrl_b_reg, ctrl_c_reg;
    ctrl_t out_ctrl;

    logic [SAMPLE_W-1:0] y_in  [NUM_PIXELS];
    logic [SAMPLE_W-1:0] cb_in [NUM_LANES];
    logic [SAMPLE_W-1:0] cr_in [NUM_LANES];
    logic [SAMPLE_W-1:0] y_reg  [NUM_PIXELS];
    logic [SAMPLE_W-1:0] cb_reg [NUM_LANES];
    logic [SAMPLE_W-1:0] cr_reg [NUM_LANES];

    pixel_t [NUM_PIXELS-1:0] lane_pix;
    pixel_t [NUM_PIXELS-1:0] out_pix;

    assign cfg_ready = 1'b1;

    // Each stage advances when it is empty or the one after it moves.
    assign ready_c  = !vc_reg || ready_o;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign s_tready = ready_a;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cb_in[0] = s_tdata[9:0];
        y_in[0]  = s_tdata[19:10];
        cr_in[0] = s_tdata[29:20];
        y_in[1]  = s_tdata[41:32];
        cb_in[1] = s_tdata[51:42];
        y_in[2]  = s_tdata[61:52];
        cr_in[1] = s_tdata[73:64];
        y_in[3]  = s_tdata[83:74];
        cb_in[2] = s_tdata[93:84];
        y_in[4]  = s_tdata[105:96];
        cr_in[2] = s_tdata[115:106];
        y_in[5]  = s_tdata[125:116];
    end

    v2g_pos #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .ctrl      (ctrl_cur)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                va_reg <= accept && ctrl_cur.produce;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
            if (ready_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl_a_reg <= ctrl_cur;
            y_reg      <= y_in;
            cb_reg     <= cb_in;
            cr_reg     <= cr_in;
        end
        if (ready_b) begin
            ctrl_b_reg <= ctrl_a_reg;
        end
        if (ready_c) begin
            ctrl_c_reg <= ctrl_b_reg;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        v2g_lane u_lane (
            .aclk (aclk),
            .en_b (ready_b),
            .en_c (ready_c),
            .y0   (y_reg[2*k]),
            .y1   (y_reg[2*k+1]),
            .cb   (cb_reg[k]),
            .cr   (cr_reg[k]),
            .pix  (lane_pix[2*k+1:2*k])
        );
    end

    v2g_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vc_reg),
        .in_pix    (lane_pix),
        .in_ctrl   (ctrl_c_reg),
        .in_ready  (ready_o),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_ctrl  (out_ctrl)
    );

    assign m_tdata = {(OUT_DATA_W - COUNT_LSB - COUNT_W)'(0), out_ctrl.pix_count, out_pix};
    assign m_tlast = out_ctrl.line_end;
    assign m_tuser = out_ctrl.frame_end;

endmodule

// ===== src/v2g_checker.sv =====
// Port-level checks on the converter's result stream, bound to the top level.
`include "v210_group_to_rgb_defines.svh"

module v2g_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [v2g_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import v2g_pkg::*;

    logic [COUNT_W-1:0] cnt;
    logic [PIXEL_W-1:0] last_pix;

    assign cnt      = m_tdata[COUNT_LSB +: COUNT_W];
    assign last_pix = m_tdata[COUNT_LSB-1 -: PIXEL_W];

    `V2G_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")
    `V2G_ASSERT(a_count, m_tvalid, cnt != 3'd0 && cnt != 3'd7, "pixel count out of range")
    `V2G_ASSERT(a_frame, m_tvalid && m_tuser, m_tlast, "frame end without line end")
    `V2G_ASSERT(a_full, m_tvalid && !m_tlast, cnt == 3'd6, "short group before line end")
    `V2G_ASSERT(a_blank, m_tvalid && cnt != 3'd6, last_pix == '0, "unused pixel slot not zero")

endmodule

bind v210_group_to_rgb v2g_checker u_checker (.*);
